>>> hdl/s256d_pkg.sv
// ----------------------------------------------------------------------------
// s256d_pkg
// Shared types, round constants and SHA-256 round/schedule functions.
// ----------------------------------------------------------------------------
package s256d_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] st_t;    // [0] = a ... [7] = h
  typedef word_t [15:0] win_t;  // message window, [0] is the word of this round

  typedef struct packed {
    logic  valid;
    word_t nonce;
    st_t   base;  // chaining value added back at the end of the compression
    st_t   v;
    win_t  w;
  } stg_t;

  localparam int HdrWords = 19;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_HASH = 1'b1;

  localparam word_t PAD_ONE  = 32'h8000_0000;
  localparam word_t LEN_HDR  = 32'h0000_0480;
  localparam word_t LEN_DIG  = 32'h0000_0300;

  localparam st_t IV = {
    32'h9f75c9ad, 32'h8fd52e5b, 32'h475bbf30, 32'haa3ff126,
    32'hd338e869, 32'h6bb01122, 32'hb72074d4, 32'hdfa9bf2c
  };

  localparam word_t K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t swap32(input word_t x);
    swap32 = {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic st_t round_f(input st_t v, input word_t k, input word_t w);
    word_t e1, ch, t1, a0, mj, t2;
    st_t r;
    e1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1 = v[7] + e1 + ch + k + w;
    a0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2 = a0 + mj;
    r[7] = v[6];
    r[6] = v[5];
    r[5] = v[4];
    r[4] = v[3] + t1;
    r[3] = v[2];
    r[2] = v[1];
    r[1] = v[0];
    r[0] = t1 + t2;
    round_f = r;
  endfunction

  // Advance the window by one word, appending the next schedule word.
  function automatic win_t shift_w(input win_t w);
    word_t s0, s1;
    win_t r;
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    for (int i = 0; i < 15; i++) r[i] = w[i + 1];
    r[15] = w[0] + s0 + w[9] + s1;
    shift_w = r;
  endfunction

endpackage

>>> hdl/s256d_stage.sv
// ----------------------------------------------------------------------------
// s256d_stage
// One registered SHA-256 round with its schedule step.
// ----------------------------------------------------------------------------
module s256d_stage import s256d_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  word_t kc,
  input  stg_t  d,
  output stg_t  q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= d.valid;
    end
    if (en) begin
      q.nonce <= d.nonce;
      q.base  <= d.base;
      q.v     <= round_f(d.v, kc, d.w[0]);
      q.w     <= shift_w(d.w);
    end
  end

endmodule

>>> hdl/s256d_mid.sv
// ----------------------------------------------------------------------------
// s256d_mid
// Iterative first-block compression: one round per cycle from the fixed IV.
// ----------------------------------------------------------------------------
module s256d_mid import s256d_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  win_t blk,
  output logic busy,
  output logic done,
  output st_t  mid
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic       state;
  logic [5:0] cnt;
  st_t        v;
  win_t       w;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_RUN;
            cnt   <= '0;
          end
        end
        ST_RUN: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      v <= IV;
      w <= blk;
    end else if (state == ST_RUN) begin
      v <= round_f(v, K[cnt], w[0]);
      w <= shift_w(w);
    end
  end

  assign busy = (state == ST_RUN);

  // high during the last round, so the state is fresh when busy drops
  assign done = (state == ST_RUN) && (cnt == 6'd63);

  always_comb begin
    for (int i = 0; i < 8; i++) mid[i] = IV[i] + v[i];
  end

endmodule

>>> hdl/sha256_custom_iv_double_hash_check.sv
// ----------------------------------------------------------------------------
// sha256_custom_iv_double_hash_check
// Double SHA-256 nonce hasher with custom IV, cached first block, target check.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                   | tuser
//  s_*      | in  | word_index 5, word_value 32, nonce 32 | opcode
//  m_*      | out | nonce_out 32, hash_w0..hash_w7 32     | hit
//  cfg_*    | in  | index 4 bits, data 32 (target words)  | -
//
// One item per cycle unless the output stalls or the first-block unit is busy.
// After reset or a header load the first hash waits while the iterative
// first-block unit runs 64 rounds; loads are held off meanwhile.
// A stall on m_tready freezes the whole round pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module sha256_custom_iv_double_hash_check import s256d_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [71:0]  s_tdata,   // word_index, word_value, nonce, zero fill
  input  logic [0:0]   s_tuser,   // opcode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [287:0] m_tdata,   // nonce_out, hash_w0 .. hash_w7
  output logic [0:0]   m_tuser,   // hit
  input  logic         cfg_we,
  input  logic [3:0]   cfg_addr,
  input  logic [31:0]  cfg_data
);

  logic       en, acc, stale, busy, done, start;
  logic [4:0] widx;
  word_t      hdr [HdrWords];
  word_t      tgt [8];
  win_t       blk1;
  st_t        mid;
  stg_t       s2 [65];
  stg_t       s3 [65];
  st_t        dig;
  logic       fv;
  word_t      fnonce;
  st_t        fh;
  logic [255:0] hv, tv;

  assign en    = !m_tvalid || m_tready;
  assign start = s_tvalid && s_tuser[0] == OP_HASH && stale && !busy;
  assign s_tready = en && !busy && !(stale && s_tuser[0] == OP_HASH);
  assign acc   = s_tvalid && s_tready;
  assign widx  = s_tdata[4:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 7; i++) tgt[i] <= 32'hffff_ffff;
      tgt[7] <= '0;
    end else if (cfg_we && cfg_addr[3] == 1'b0) begin
      tgt[cfg_addr[2:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HdrWords; i++) hdr[i] <= '0;
      stale <= 1'b1;
    end else begin
      if (done) stale <= 1'b0;
      if (acc && s_tuser[0] == OP_LOAD && widx < 5'(HdrWords)) begin
        hdr[widx] <= s_tdata[36:5];
        stale     <= 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) blk1[i] = hdr[i];
  end

  s256d_mid u_mid (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .blk  (blk1),
    .busy (busy),
    .done (done),
    .mid  (mid)
  );

  // entry register: second block built from header tail and nonce
  always_ff @(posedge clk) begin
    if (rst) begin
      s2[0].valid <= 1'b0;
    end else if (en) begin
      s2[0].valid <= acc && s_tuser[0] == OP_HASH;
    end
    if (en) begin
      s2[0].nonce <= s_tdata[68:37];
      s2[0].base  <= mid;
      s2[0].v     <= mid;
      s2[0].w     <= {LEN_HDR, {10{32'h0}}, PAD_ONE, s_tdata[68:37],
                      hdr[18], hdr[17], hdr[16]};
    end
  end

  for (genvar g = 0; g < 64; g++) begin : g_c2
    s256d_stage u_st (
      .clk(clk), .rst(rst), .en(en), .kc(K[g]), .d(s2[g]), .q(s2[g + 1])
    );
  end

  always_comb begin
    for (int i = 0; i < 8; i++) dig[i] = s2[64].base[i] + s2[64].v[i];
  end

  // join: feed forward the second block and pad the digest as a new block
  always_ff @(posedge clk) begin
    if (rst) begin
      s3[0].valid <= 1'b0;
    end else if (en) begin
      s3[0].valid <= s2[64].valid;
    end
    if (en) begin
      s3[0].nonce <= s2[64].nonce;
      s3[0].base  <= IV;
      s3[0].v     <= IV;
      s3[0].w     <= {LEN_DIG, {6{32'h0}}, PAD_ONE, dig};
    end
  end

  for (genvar g = 0; g < 64; g++) begin : g_c3
    s256d_stage u_st (
      .clk(clk), .rst(rst), .en(en), .kc(K[g]), .d(s3[g]), .q(s3[g + 1])
    );
  end

  // final feed forward and byte swap
  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (en) begin
      fv <= s3[64].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fnonce <= s3[64].nonce;
      for (int i = 0; i < 8; i++) fh[i] <= swap32(IV[i] + s3[64].v[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      hv[32*i +: 32] = fh[i];
      tv[32*i +: 32] = tgt[i];
    end
  end

  // output register: compare against target
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= fv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata    <= {hv, fnonce};
      m_tuser[0] <= (hv <= tv);
    end
  end

  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_tready)
    else $error("input accepted while first block runs");

  a_done_fresh: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> !stale)
    else $error("first block done but still stale");

  a_hash_fresh: assert property (@(posedge clk) disable iff (rst)
    (acc && s_tuser[0] == OP_HASH) |-> (!stale && !busy))
    else $error("hash item taken with stale first block");

  a_entry: assert property (@(posedge clk) disable iff (rst)
    (acc && s_tuser[0] == OP_HASH) |=> s2[0].valid)
    else $error("hash item lost at pipeline entry");

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives header loads and nonce hashes into the double SHA-256 checker and
// compares every hash result against a behavioral double-hash predictor.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import s256d_pkg::*;

  typedef struct {
    word_t nonce;
    word_t h [8];
    bit    hit;
  } hash_res_t;

  class hash_scoreboard;
    word_t     target [8];
    word_t     header [19];
    word_t     mid_state [8];
    bit        mid_ok;
    hash_res_t pending [$];
    int        errors;

    function void clear();
      for (int i = 0; i < 7; i++) target[i] = '1;
      target[7] = '0;
      foreach (header[i]) header[i] = '0;
      mid_ok = 0;
      pending.delete();
      errors = 0;
    endfunction

    function word_t rr(word_t x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void sha_block(output word_t dst [8], input word_t msg [16],
                            input word_t init [8]);
      word_t w [64];
      word_t v [8];
      word_t t1, t2;
      for (int i = 0; i < 16; i++) w[i] = msg[i];
      for (int i = 16; i < 64; i++)
        w[i] = w[i-16] + w[i-7]
             + (rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3))
             + (rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10));
      v = init;
      for (int i = 0; i < 64; i++) begin
        t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K[i] + w[i];
        t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) dst[i] = init[i] + v[i];
    endfunction

    function void note_item(bit op, logic [4:0] idx, word_t val, word_t nonce);
      word_t iv [8];
      word_t blk [16];
      word_t mid [8];
      word_t fin [8];
      hash_res_t r;
      for (int i = 0; i < 8; i++) iv[i] = IV[i];
      if (op == OP_LOAD) begin
        if (idx < HdrWords) begin
          header[idx] = val;
          mid_ok = 0;
        end
        return;
      end
      if (!mid_ok) begin
        for (int i = 0; i < 16; i++) blk[i] = header[i];
        sha_block(mid_state, blk, iv);
        mid_ok = 1;
      end
      foreach (blk[i]) blk[i] = '0;
      blk[0] = header[16]; blk[1] = header[17]; blk[2] = header[18];
      blk[3] = nonce; blk[4] = PAD_ONE; blk[15] = LEN_HDR;
      sha_block(mid, blk, mid_state);
      foreach (blk[i]) blk[i] = '0;
      for (int i = 0; i < 8; i++) blk[i] = mid[i];
      blk[8] = PAD_ONE; blk[15] = LEN_DIG;
      sha_block(fin, blk, iv);
      r.nonce = nonce;
      for (int i = 0; i < 8; i++)
        r.h[i] = {fin[i][7:0], fin[i][15:8], fin[i][23:16], fin[i][31:24]};
      r.hit = 1;
      for (int i = 7; i >= 0; i--) begin
        if (r.h[i] > target[i]) begin r.hit = 0; break; end
        if (r.h[i] < target[i]) break;
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [287:0] d, logic hit);
      hash_res_t e;
      if (pending.size() == 0) begin
        $error("unexpected hash result nonce %h", d[31:0]);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e.nonce) begin
        $error("nonce_out exp %h got %h", e.nonce, d[31:0]);
        errors++;
      end
      for (int i = 0; i < 8; i++)
        if (d[32*(i+1) +: 32] !== e.h[i]) begin
          $error("hash_w%0d exp %h got %h", i, e.h[i], d[32*(i+1) +: 32]);
          errors++;
        end
      if (hit !== e.hit) begin
        $error("hit exp %0d got %0d", e.hit, hit);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tready;
  logic [71:0] s_tdata = '0;   // word_index, word_value, nonce, zero fill
  logic [0:0] s_tuser = '0;    // opcode
  logic m_tvalid, m_tready = 0;
  logic [287:0] m_tdata;       // nonce_out, hash_w0 .. hash_w7
  logic [0:0] m_tuser;         // hit
  logic cfg_we = 0;
  logic [3:0] cfg_addr = '0;
  logic [31:0] cfg_data = '0;

  int src_idle = 0, sink_stall = 0;
  hash_scoreboard sb = new();

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  sha256_custom_iv_double_hash_check DUT (.*);

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0]);
      m_tready <= ($urandom_range(99) >= sink_stall);
    end
  end

  // valid stays up after an accepted item until the next idle cycle or task
  task automatic push_item(bit op, logic [4:0] idx, word_t val, word_t nonce);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= op;
    s_tdata <= {3'b0, nonce, val, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(op, idx, val, nonce);
  endtask

  task automatic load_word(logic [4:0] idx, word_t val);
    push_item(OP_LOAD, idx, val, $urandom);
  endtask

  task automatic hash_nonce(word_t nonce);
    push_item(OP_HASH, 5'($urandom), $urandom, nonce);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_target(logic [3:0] a, word_t v);
    s_tvalid <= 0;
    cfg_we <= 1;
    cfg_addr <= a;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    if (a < 8) sb.target[a] = v;
    @(posedge clk);
  endtask

  // Mode 0 clears, mode 1 sets all ones, others pick random words with a small top word; set all words.
  task automatic set_targets(int mode);
    for (int i = 0; i < 8; i++)
      case (mode)
        0: write_target(4'(i), '0);
        1: write_target(4'(i), '1);
        default: write_target(4'(i), (i == 7) ? $urandom_range(32'h0fff_ffff) : $urandom);
      endcase
  endtask

  task automatic random_phase(int n);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0: load_word(5'($urandom_range(31)), $urandom);
        1, 2: load_word(5'($urandom_range(18)), $urandom);
        default: hash_nonce($urandom);
      endcase
    end
  endtask

  initial begin
    sb.clear();
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // hash on the all-zero header, then extremes of every field
    hash_nonce('0);
    hash_nonce('1);
    load_word(5'd0, '1);
    load_word(5'd18, '1);
    hash_nonce(32'h8000_0001);
    load_word(5'd19, 32'hdead_beef);
    load_word(5'd31, '1);
    hash_nonce(32'h1234_5678);
    load_word(5'd16, 32'h5555_5555);
    hash_nonce(32'haaaa_aaaa);
    load_word(5'd17, '0);
    load_word(5'd15, 32'h0000_0001);
    hash_nonce(32'h0000_0001);
    hash_nonce(32'hffff_fffe);
    drain();
    set_targets(1);
    hash_nonce($urandom);
    hash_nonce($urandom);
    drain();
    set_targets(0);
    write_target(4'd8, '0);
    write_target(4'd15, '1);
    hash_nonce($urandom);
    drain();
    for (int i = 0; i < 19; i++) load_word(5'(i), $urandom);
    set_targets(2);
    random_phase(100);
    src_idle = 68;
    random_phase(100);
    // let the pipe empty before the next burst
    drain();
    src_idle = 0;
    sink_stall = 68;
    set_targets(2);
    random_phase(100);
    src_idle = 38;
    sink_stall = 38;
    random_phase(100);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

>>> files.f
hdl/s256d_pkg.sv
hdl/s256d_stage.sv
hdl/s256d_mid.sv
hdl/sha256_custom_iv_double_hash_check.sv
test/tb_top.sv
